/* src/apcu_pkg.sv */
// Shared types, codes and helper functions for the address prefix compare unit.
package apcu_pkg;

  // Operation codes
  typedef enum logic [1:0] {
    OpCompare    = 2'd0,
    OpMatch      = 2'd1,
    OpCommon     = 2'd2,
    OpCommonHost = 2'd3
  } op_e;

  // Address type codes
  typedef enum logic [1:0] {
    AddrIpv4     = 2'd0,
    AddrIpv6     = 2'd1,
    AddrEthernet = 2'd2,
    AddrFirewire = 2'd3
  } addr_e;

  // Result status codes
  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StType = 2'd1,
    StLen  = 2'd2
  } status_e;

  // Order result codes, two's complement
  localparam logic [1:0] OrdBelow = 2'b11;
  localparam logic [1:0] OrdEqual = 2'b00;
  localparam logic [1:0] OrdAbove = 2'b01;

  localparam logic [7:0] Ipv4MaxLen = 8'd32;
  localparam logic [7:0] Ipv6MaxLen = 8'd128;
  localparam logic [7:0] HalfBits   = 8'd64;
  localparam logic [5:0] HostLimit  = 6'd31;

  // Stage 1: raw compare flags, match hits and IPv4 words
  typedef struct packed {
    op_e         op;
    addr_e       ta;
    addr_e       tb;
    logic [7:0]  len;
    logic        hi_eq;
    logic        hi_lt;
    logic        lo_eq;
    logic        lo_lt;
    logic        v4_hit;
    logic        v6_hit;
    logic [31:0] a32;
    logic [31:0] b32;
  } s1_t;

  // Stage 2: decoded results and bit counts
  typedef struct packed {
    op_e        op;
    status_e    status;
    logic [1:0] order;
    logic       in_prefix;
    logic [5:0] lead;
    logic [5:0] tz_a;
    logic [5:0] to_a;
    logic [5:0] tz_b;
    logic [5:0] to_b;
  } s2_t;

  // Mask of the bits that an address type uses in the low word
  function automatic logic [63:0] width_mask(addr_e t);
    logic [63:0] m;
    unique case (t)
      AddrIpv4:     m = 64'h0000_0000_ffff_ffff;
      AddrEthernet: m = 64'h0000_ffff_ffff_ffff;
      default:      m = '1;
    endcase
    return m;
  endfunction

  // Count of leading zeros, 32 for an all-zero word
  function automatic logic [5:0] lead_zeros32(logic [31:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd32;
    hit = 1'b0;
    for (int k = 31; k >= 0; k--) begin
      if (!hit && v[k]) begin
        n   = 6'(31 - k);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Count of trailing zeros, 32 for an all-zero word
  function automatic logic [5:0] trail_zeros32(logic [31:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd32;
    hit = 1'b0;
    for (int k = 0; k < 32; k++) begin
      if (!hit && v[k]) begin
        n   = 6'(k);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] max6(logic [5:0] x, logic [5:0] y);
    return (x > y) ? x : y;
  endfunction

endpackage

/* src/address_prefix_compare_unit.sv */
// Top level of the address prefix compare unit: three-stage compare and prefix pipeline.
//
// One item is accepted in every cycle: busy_o stays low and start_i alone admits an item.
// Each item gives one result in order. valid_o is registered alongside the result and
// rises when the result register loads. The pipeline has three register stages
// (compare and mask, bit counting and decode, host reduction and result register).
// The receiver cannot stall, so results must be taken in the cycle they appear.
module address_prefix_compare_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            op_i,
  input  logic [1:0]            type_a_i,
  input  logic [1:0]            type_b_i,
  input  logic [63:0]           a_hi_i,
  input  logic [63:0]           a_lo_i,
  input  logic [63:0]           b_hi_i,
  input  logic [63:0]           b_lo_i,
  input  logic [7:0]            prefix_len_i,
  output logic                  valid_o,
  output logic [1:0]            status_o,
  output logic signed [1:0]     order_o,
  output logic                  in_prefix_o,
  output logic [5:0]            common_len_o
);
  import apcu_pkg::*;

  logic        v1_q, v2_q, v3_q;
  s1_t         s1_d, s1_q;
  s2_t         s2_d, s2_q;
  logic [1:0]  status_d, status_q;
  logic [1:0]  order_d, order_q;
  logic        in_prefix_d, in_prefix_q;
  logic [5:0]  common_d, common_q;

  logic [63:0] wmask;
  logic [63:0] alo_m, blo_m, ahi_m, bhi_m;
  logic [31:0] v4_mask;
  logic [63:0] v6_mh, v6_ml;
  logic [7:0]  len_lo;
  logic [31:0] x32;

  logic [5:0]  ext_max;
  logic [5:0]  host_cap;
  logic [5:0]  reduced;

  // Stage 1: mask addresses, compare halves, check prefix bits
  always_comb begin
    s1_d.op  = op_e'(op_i);
    s1_d.ta  = addr_e'(type_a_i);
    s1_d.tb  = addr_e'(type_b_i);
    s1_d.len = prefix_len_i;

    wmask = width_mask(addr_e'(type_a_i));
    alo_m = a_lo_i & wmask;
    blo_m = b_lo_i & wmask;
    ahi_m = (addr_e'(type_a_i) == AddrIpv6) ? a_hi_i : '0;
    bhi_m = (addr_e'(type_a_i) == AddrIpv6) ? b_hi_i : '0;

    s1_d.hi_eq = (ahi_m == bhi_m);
    s1_d.hi_lt = (ahi_m < bhi_m);
    s1_d.lo_eq = (alo_m == blo_m);
    s1_d.lo_lt = (alo_m < blo_m);

    x32     = a_lo_i[31:0] ^ b_lo_i[31:0];
    v4_mask = ~(32'hffff_ffff >> prefix_len_i);
    s1_d.v4_hit = ((x32 & v4_mask) == '0);

    len_lo = prefix_len_i - HalfBits;
    v6_mh  = ~({64{1'b1}} >> prefix_len_i);
    v6_ml  = (prefix_len_i > HalfBits) ? ~({64{1'b1}} >> len_lo) : '0;
    s1_d.v6_hit = (((a_hi_i ^ b_hi_i) & v6_mh) == '0) &&
                  (((a_lo_i ^ b_lo_i) & v6_ml) == '0);

    s1_d.a32 = a_lo_i[31:0];
    s1_d.b32 = b_lo_i[31:0];
  end

  // Stage 2: decode the operation and count bits
  always_comb begin
    s2_d.op        = s1_q.op;
    s2_d.status    = StOk;
    s2_d.order     = OrdEqual;
    s2_d.in_prefix = 1'b0;
    s2_d.lead      = lead_zeros32(s1_q.a32 ^ s1_q.b32);
    s2_d.tz_a      = trail_zeros32(s1_q.a32);
    s2_d.to_a      = trail_zeros32(~s1_q.a32);
    s2_d.tz_b      = trail_zeros32(s1_q.b32);
    s2_d.to_b      = trail_zeros32(~s1_q.b32);

    unique case (s1_q.op)
      OpCompare: begin
        if (s1_q.ta != s1_q.tb) begin
          s2_d.order = (s1_q.ta < s1_q.tb) ? OrdBelow : OrdAbove;
        end else if (!s1_q.hi_eq) begin
          s2_d.order = s1_q.hi_lt ? OrdBelow : OrdAbove;
        end else if (!s1_q.lo_eq) begin
          s2_d.order = s1_q.lo_lt ? OrdBelow : OrdAbove;
        end
      end
      OpMatch: begin
        if (s1_q.ta == AddrIpv4) begin
          if (s1_q.len > Ipv4MaxLen) s2_d.status = StLen;
          else                       s2_d.in_prefix = s1_q.v4_hit;
        end else if (s1_q.ta == AddrIpv6) begin
          if (s1_q.len > Ipv6MaxLen) s2_d.status = StLen;
          else                       s2_d.in_prefix = s1_q.v6_hit;
        end else begin
          s2_d.status = StType;
        end
      end
      default: begin
        if (s1_q.ta != s1_q.tb || s1_q.ta != AddrIpv4) s2_d.status = StType;
      end
    endcase
  end

  // Stage 3: back off the common length past host extremes, clear on error
  always_comb begin
    ext_max  = max6(max6(s2_q.tz_a, s2_q.to_a), max6(s2_q.tz_b, s2_q.to_b));
    host_cap = (ext_max >= HostLimit) ? 6'd0 : (HostLimit - ext_max);
    reduced  = (s2_q.lead < host_cap) ? s2_q.lead : host_cap;

    common_d = '0;
    if (s2_q.op == OpCommon) begin
      common_d = s2_q.lead;
    end else if (s2_q.op == OpCommonHost) begin
      common_d = (s2_q.lead >= HostLimit) ? s2_q.lead : reduced;
    end

    status_d    = s2_q.status;
    order_d     = s2_q.order;
    in_prefix_d = s2_q.in_prefix;
    if (s2_q.status != StOk) begin
      order_d     = OrdEqual;
      in_prefix_d = 1'b0;
      common_d    = '0;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    s1_q        <= s1_d;
    s2_q        <= s2_d;
    status_q    <= status_d;
    order_q     <= order_d;
    in_prefix_q <= in_prefix_d;
    common_q    <= common_d;
  end

  assign busy_o       = 1'b0;
  assign valid_o      = v3_q;
  assign status_o     = status_q;
  assign order_o      = order_q;
  assign in_prefix_o  = in_prefix_q;
  assign common_len_o = common_q;

endmodule
